[rtl/greedy_word_wrap_defines.svh]
// Assertion macros used by the block's back-end module.
// Each expects clk and rst in scope.
`ifndef GREEDY_WORD_WRAP_DEFINES_SVH
`define GREEDY_WORD_WRAP_DEFINES_SVH

// Condition holds at every edge outside reset.
`define GWW_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define GWW_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define GWW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/gww_pkg.sv]
package gww_pkg;

  localparam int WIDTH_W            = 7;
  localparam int MAX_LINE_WIDTH_DEF = 64;
  localparam logic [WIDTH_W-1:0] LINE_WIDTH_RESET = 7'd64;
  localparam int QUEUE_DEPTH        = 2;

  localparam logic [1:0] SEP_NONE  = 2'd0;
  localparam logic [1:0] SEP_SPACE = 2'd1;
  localparam logic [1:0] SEP_BREAK = 2'd2;

  typedef enum logic [1:0] {
    KIND_CHAR,
    KIND_SPACE,
    KIND_END
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } cmd_t;

endpackage

[rtl/gww_ram.sv]
module gww_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/gww_front.sv]
module gww_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    text_byte,
  input  logic          end_of_text,
  output logic          cmd_valid,
  output gww_pkg::cmd_t cmd,
  input  logic          cmd_pop
);

  localparam int QAW = $clog2(gww_pkg::QUEUE_DEPTH);

  gww_pkg::cmd_t q [gww_pkg::QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;
  gww_pkg::cmd_t  in_cmd;
  logic           push;

  // classify
  always_comb begin
    in_cmd.data = text_byte;
    if (end_of_text) begin
      in_cmd.kind = gww_pkg::KIND_END;
    end else if (text_byte inside {8'd0, 8'd32, [8'd9:8'd13]}) begin
      in_cmd.kind = gww_pkg::KIND_SPACE;
    end else begin
      in_cmd.kind = gww_pkg::KIND_CHAR;
    end
  end

  assign in_stall  = rst || (count == (QAW+1)'(gww_pkg::QUEUE_DEPTH));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (count != '0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_cmd;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !cmd_pop) begin
        count <= count + 1'b1;
      end else if (!push && cmd_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/gww_back.sv]
`include "greedy_word_wrap_defines.svh"

module gww_back #(
  parameter int MAX_LINE_WIDTH = gww_pkg::MAX_LINE_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [gww_pkg::WIDTH_W-1:0] line_width,
  input  logic                       cmd_valid,
  input  gww_pkg::cmd_t              cmd,
  output logic                       cmd_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 out_byte,
  output logic                       out_has,
  output logic [1:0]                 out_sep,
  output logic                       out_last
);

  localparam int AW    = $clog2(MAX_LINE_WIDTH);
  localparam int DEPTH = 1 << AW;
  localparam int LW    = $clog2(MAX_LINE_WIDTH + 1);

  typedef enum logic {S_IDLE, S_EMIT} state_t;
  typedef enum logic {M_CHUNK, M_FINISH} mode_t;

  state_t        state;
  mode_t         mode;
  logic [LW-1:0] word_fill;
  logic [LW-1:0] line_fill;
  logic          anything;
  logic          long_active;
  logic [AW-1:0] head;
  logic [LW-1:0] cnt;
  logic          first;
  logic [1:0]    first_sep;
  logic          is_end;
  logic          pend;
  logic [1:0]    pend_sep;
  logic          pend_last;

  logic [LW-1:0] w;
  logic          out_free;
  logic          rd_en;
  logic          load_pend;
  logic          load_mark;
  logic          wr_en;
  logic [7:0]    rdata;
  logic          len_zero;
  logic          go_long;
  logic [LW:0]   joined;
  logic [LW-1:0] chunk_cnt;
  logic [1:0]    brk_sep;
  logic [1:0]    norm_sep;
  logic [LW-1:0] norm_line;
  logic          emit_done;

  always_comb begin
    if (line_width == '0 || line_width > gww_pkg::WIDTH_W'(MAX_LINE_WIDTH)) begin
      w = LW'(MAX_LINE_WIDTH);
    end else begin
      w = LW'(line_width);
    end
  end

  assign out_free  = !out_valid || !out_stall;
  assign rd_en     = (state == S_EMIT) && (cnt != '0) && (!pend || out_free);
  assign load_pend = pend && out_free;
  assign len_zero  = (word_fill == '0);
  assign load_mark = (state == S_IDLE) && cmd_valid && (cmd.kind == gww_pkg::KIND_END)
                     && len_zero && out_free;
  assign go_long   = long_active || (word_fill > w);
  assign joined    = {1'b0, line_fill} + (LW+1)'(1) + {1'b0, word_fill};
  assign chunk_cnt = (word_fill < w) ? word_fill : w;
  assign brk_sep   = anything ? gww_pkg::SEP_BREAK : gww_pkg::SEP_NONE;
  assign emit_done = (state == S_EMIT) && (cnt == '0) && !pend;
  assign wr_en     = (state == S_IDLE) && cmd_valid && (cmd.kind == gww_pkg::KIND_CHAR)
                     && (word_fill < w);

  always_comb begin
    if (line_fill == '0) begin
      norm_sep  = brk_sep;
      norm_line = word_fill;
    end else if (joined <= {1'b0, w}) begin
      norm_sep  = gww_pkg::SEP_SPACE;
      norm_line = joined[LW-1:0];
    end else begin
      norm_sep  = gww_pkg::SEP_BREAK;
      norm_line = word_fill;
    end
  end

  always_comb begin
    cmd_pop = 1'b0;
    if (state == S_IDLE && cmd_valid) begin
      case (cmd.kind)
        gww_pkg::KIND_CHAR:  cmd_pop = (word_fill < w);
        gww_pkg::KIND_SPACE: cmd_pop = len_zero;
        gww_pkg::KIND_END:   cmd_pop = len_zero && out_free;
        default:             cmd_pop = 1'b0;
      endcase
    end else if (emit_done && mode == M_FINISH && len_zero) begin
      cmd_pop = 1'b1;
    end
  end

  gww_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (wr_en),
    .waddr(head + word_fill[AW-1:0]),
    .wdata(cmd.data),
    .re   (rd_en),
    .raddr(head),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      mode        <= M_CHUNK;
      word_fill   <= '0;
      line_fill   <= '0;
      anything    <= 1'b0;
      long_active <= 1'b0;
      head        <= '0;
      cnt         <= '0;
      first       <= 1'b0;
      is_end      <= 1'b0;
      pend        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (load_pend) begin
        out_valid <= 1'b1;
        out_byte  <= rdata;
        out_has   <= 1'b1;
        out_sep   <= pend_sep;
        out_last  <= pend_last;
      end else if (load_mark) begin
        out_valid <= 1'b1;
        out_byte  <= '0;
        out_has   <= 1'b0;
        out_sep   <= gww_pkg::SEP_NONE;
        out_last  <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      // advance read side
      if (rd_en) begin
        pend      <= 1'b1;
        pend_sep  <= first ? first_sep : gww_pkg::SEP_NONE;
        pend_last <= is_end && (word_fill == LW'(1));
        first     <= 1'b0;
        cnt       <= cnt - 1'b1;
        word_fill <= word_fill - 1'b1;
        head      <= head + 1'b1;
      end else if (load_pend) begin
        pend <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            if (cmd.kind == gww_pkg::KIND_CHAR) begin
              if (word_fill >= w) begin
                mode        <= M_CHUNK;
                cnt         <= w;
                first       <= 1'b1;
                first_sep   <= brk_sep;
                anything    <= 1'b1;
                line_fill   <= '0;
                long_active <= 1'b1;
                is_end      <= 1'b0;
                state       <= S_EMIT;
              end else begin
                word_fill <= word_fill + 1'b1;
              end
            end else if (len_zero) begin
              if (cmd.kind == gww_pkg::KIND_END && out_free) begin
                line_fill   <= '0;
                anything    <= 1'b0;
                long_active <= 1'b0;
                head        <= '0;
              end
            end else if (go_long) begin
              mode        <= M_FINISH;
              cnt         <= chunk_cnt;
              first       <= 1'b1;
              first_sep   <= brk_sep;
              anything    <= 1'b1;
              line_fill   <= '0;
              long_active <= 1'b1;
              is_end      <= (cmd.kind == gww_pkg::KIND_END);
              state       <= S_EMIT;
            end else begin
              mode      <= M_FINISH;
              cnt       <= word_fill;
              first     <= 1'b1;
              first_sep <= norm_sep;
              anything  <= 1'b1;
              line_fill <= norm_line;
              is_end    <= (cmd.kind == gww_pkg::KIND_END);
              state     <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (emit_done) begin
            state <= S_IDLE;
            if (mode == M_FINISH && len_zero) begin
              long_active <= 1'b0;
              if (is_end) begin
                line_fill <= '0;
                anything  <= 1'b0;
                head      <= '0;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `GWW_ASSERT_ALWAYS(a_len_bound, word_fill <= LW'(MAX_LINE_WIDTH), "word length over max")
  `GWW_ASSERT_IMP(a_pend_in_emit, pend, state == S_EMIT, "read pending outside emit")
  `GWW_ASSERT_IMP(a_marker_last, out_valid && !out_has, out_last, "marker without last flag")
  `GWW_ASSERT_NEXT(a_read_fills, rd_en, pend, "read issued but nothing pending")

endmodule

[rtl/greedy_word_wrap.sv]
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   text_byte, end_of_text
// out      output     out_valid / out_stall out_byte, has_byte, separator, last_of_text
// cfg      input      cfg_valid / cfg_ready line_width
//
// A character is queued, then written to the word store; a queue of two items
// sits ahead of the word store.
// A finished word drains one byte per cycle from the single-port-read word
// store while the output is not stalled.
// Reset is synchronous; no clearing pass, the word store is written before read.
// A stalled output holds the drain; the input queue then fills and stalls.
module greedy_word_wrap #(
  parameter int MAX_LINE_WIDTH = gww_pkg::MAX_LINE_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  text_byte,
  input  logic                        end_of_text,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_byte,
  output logic                        has_byte,
  output logic [1:0]                  separator,
  output logic                        last_of_text,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [gww_pkg::WIDTH_W-1:0] line_width
);

  logic [gww_pkg::WIDTH_W-1:0] width_reg;
  logic                        cmd_valid;
  gww_pkg::cmd_t               cmd;
  logic                        cmd_pop;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg <= gww_pkg::LINE_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      width_reg <= line_width;
    end
  end

  gww_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .text_byte  (text_byte),
    .end_of_text(end_of_text),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  gww_back #(
    .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .line_width(width_reg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_has   (has_byte),
    .out_sep   (separator),
    .out_last  (last_of_text)
  );

endmodule
